// ===== rtl/prefix_code_bit_decoder_defines.svh =====
// Assertion macros used by the decoder controller.
`ifndef PREFIX_CODE_BIT_DECODER_DEFINES_SVH
`define PREFIX_CODE_BIT_DECODER_DEFINES_SVH

// Check that a condition implies a consequent in the same cycle.
`define PCBD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcbd assertion failed");

// Check that a condition implies a consequent in the next cycle.
`define PCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcbd assertion failed");

`endif

// ===== rtl/pcbd_pkg.sv =====
// Package with the types, constants and codes of the prefix code bit decoder.
package pcbd_pkg;

    localparam int NUM_CODES_DEF        = 64;
    localparam int MAX_CODE_BITS_DEF    = 29;
    localparam int MAX_SYMBOL_BYTES_DEF = 8;

    localparam int IDX_FIELD_W = 6;
    localparam int CODE_W      = 29;
    localparam int CLEN_W      = 5;
    localparam int SYM_W       = 64;
    localparam int SLEN_W      = 4;
    localparam int CFG_W       = 7;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_BIT    = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic [IDX_FIELD_W-1:0] entry_index;
        logic [CODE_W-1:0]      entry_code;
        logic [CLEN_W-1:0]      entry_code_length;
        logic [SYM_W-1:0]       entry_symbol;
        logic [SLEN_W-1:0]      entry_symbol_length;
        logic                   code_bit;
    } t_in_item;

    typedef struct packed {
        logic                   status;
        logic [IDX_FIELD_W-1:0] matched_index;
        logic [SYM_W-1:0]       symbol_word;
        logic [SLEN_W-1:0]      symbol_length;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_FETCH
    } t_state;

    typedef struct packed {
        logic take;
        logic cfg_write;
        logic find;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_stat;

endpackage

// ===== rtl/pcbd_datapath.sv =====
// Datapath of the decoder: code table, match cells, priority search, symbol memory, output register.
module pcbd_datapath import pcbd_pkg::*; #(
    parameter int NUM_CODES        = NUM_CODES_DEF,
    parameter int MAX_CODE_BITS    = MAX_CODE_BITS_DEF,
    parameter int MAX_SYMBOL_BYTES = MAX_SYMBOL_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  t_in_item         i_in,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output t_out_item        o_out
);

    localparam int IDX_W   = $clog2(NUM_CODES);
    localparam int POS_W   = $clog2(MAX_CODE_BITS);
    localparam int CNT_W   = $clog2(NUM_CODES + 1);
    localparam int MEM_W   = SYM_W + SLEN_W;
    localparam int NBYTES  = SYM_W / 8;
    localparam int CMP_W   = 6;

    logic [CODE_W-1:0] r_code [NUM_CODES];
    logic [CLEN_W-1:0] r_clen [NUM_CODES];
    logic [MEM_W-1:0]  r_mem  [NUM_CODES];
    logic [NUM_CODES-1:0] r_alive;
    logic [POS_W-1:0]     r_pos;
    logic [CNT_W-1:0]     r_count;
    logic [NUM_CODES-1:0] r_hit;
    logic                 r_bad;
    logic                 r_sel_bad;
    logic [IDX_W-1:0]     r_sel_idx;
    logic [MEM_W-1:0]     r_rd;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [NUM_CODES-1:0] n_live;
    logic [NUM_CODES-1:0] n_done;
    logic                 any_live;
    logic                 any_done;
    logic                 wr_ok;
    logic [IDX_W-1:0]     wr_slot;
    logic                 take_wr;
    logic                 take_bit;
    logic                 restart;
    logic [IDX_W-1:0]     sel_idx;
    logic [SLEN_W-1:0]    sl_sat;
    logic [SYM_W-1:0]     word_masked;
    logic [CNT_W-1:0]     n_count;

    always_comb begin
        for (int i = 0; i < NUM_CODES; i++) begin
            n_live[i] = (r_clen[i] != '0)
                && (CMP_W'(r_clen[i]) <= CMP_W'(MAX_CODE_BITS))
                && (CMP_W'(r_pos) < CMP_W'(r_clen[i]))
                && (32'(i) < 32'(r_count))
                && ((r_pos == '0) || r_alive[i])
                && (1'(r_code[i] >> r_pos) == i_in.code_bit);
            n_done[i] = n_live[i]
                && (CMP_W'(r_clen[i]) == CMP_W'(r_pos) + CMP_W'(1));
        end
    end

    assign any_live = |n_live;
    assign any_done = |n_done;
    assign wr_ok    = 32'(i_in.entry_index) < 32'(NUM_CODES);
    assign wr_slot  = IDX_W'(i_in.entry_index);
    assign take_wr  = i_cmd.take && (i_in.req_type == REQ_WRITE);
    assign take_bit = i_cmd.take && (i_in.req_type == REQ_BIT);
    assign restart  = i_cmd.cfg_write || take_wr || (take_bit && (any_done || !any_live));
    assign n_count  = (32'(i_cfg_data) > 32'(NUM_CODES)) ? CNT_W'(NUM_CODES)
                                                         : CNT_W'(i_cfg_data);

    always_comb begin
        sel_idx = '0;
        for (int i = NUM_CODES - 1; i >= 0; i--) begin
            if (r_hit[i]) begin
                sel_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        sl_sat = r_rd[SLEN_W-1:0];
        if (32'(sl_sat) > 32'(MAX_SYMBOL_BYTES)) begin
            sl_sat = SLEN_W'(MAX_SYMBOL_BYTES);
        end
        for (int b = 0; b < NBYTES; b++) begin
            word_masked[b*8 +: 8] = (32'(b) < 32'(sl_sat)) ? r_rd[SLEN_W + b*8 +: 8] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_wr && wr_ok) begin
            r_code[wr_slot] <= i_in.entry_code;
            r_clen[wr_slot] <= i_in.entry_code_length;
            r_mem[wr_slot]  <= {i_in.entry_symbol, i_in.entry_symbol_length};
        end
        if (i_cmd.find) begin
            r_rd <= r_mem[sel_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive     <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_write) begin
                r_count <= n_count;
            end
            if (restart) begin
                r_alive <= '0;
                r_pos   <= '0;
            end else if (take_bit) begin
                r_alive <= n_live;
                r_pos   <= r_pos + POS_W'(1);
            end
            if (i_cmd.load && (r_bad || (|r_hit))) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_bit) begin
            r_hit <= n_done;
            r_bad <= !any_live;
        end
        if (i_cmd.find) begin
            r_sel_bad <= r_bad;
            r_sel_idx <= sel_idx;
        end
        if (i_cmd.load) begin
            if (r_sel_bad) begin
                r_out.status        <= STATUS_BAD;
                r_out.matched_index <= '0;
                r_out.symbol_word   <= '0;
                r_out.symbol_length <= '0;
            end else begin
                r_out.status        <= STATUS_OK;
                r_out.matched_index <= IDX_FIELD_W'(r_sel_idx);
                r_out.symbol_word   <= word_masked;
                r_out.symbol_length <= sl_sat;
            end
        end
    end

    assign o_stat.out_full = r_out_valid;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

endmodule

// ===== rtl/pcbd_ctrl.sv =====
// Controller state machine of the decoder: request acceptance and result sequencing.
`include "prefix_code_bit_decoder_defines.svh"

module pcbd_ctrl import pcbd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_is_bit,
    input  logic i_cfg_valid,
    input  logic i_out_stall,
    input  t_stat i_stat,
    output logic o_in_stall,
    output logic o_cfg_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_stall      = 1'b1;
        o_cfg_ready     = 1'b0;
        o_cmd.take      = 1'b0;
        o_cmd.cfg_write = 1'b0;
        o_cmd.find      = 1'b0;
        o_cmd.load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall      = i_stat.out_full && i_out_stall;
                o_cfg_ready     = 1'b1;
                o_cmd.cfg_write = i_cfg_valid;
                o_cmd.take      = i_in_valid && !o_in_stall;
                if (o_cmd.take && i_in_is_bit) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                n_state    = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.load = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `PCBD_ASSERT_NEXT(a_bit_to_find, i_clk, i_rst_n, o_cmd.take && i_in_is_bit, r_state == S_FIND)
    `PCBD_ASSERT_NEXT(a_find_to_fetch, i_clk, i_rst_n, r_state == S_FIND, r_state == S_FETCH)
    `PCBD_ASSERT_SAME(a_load_empty, i_clk, i_rst_n, o_cmd.load, !i_stat.out_full)

endmodule

// ===== rtl/prefix_code_bit_decoder.sv =====
// Top level of the prefix code bit decoder: controller and datapath.
// Table write request: no result; the controller stays idle, ready for the next request.
// Code bit request: match compare into hit marks, then priority search over hits and symbol
//   memory read in find, output register load in fetch; no new request is taken until idle.
// Reset (synchronous, active low) clears entry count, live marks, code position, state, out valid.
// Table contents are undefined until written.
module prefix_code_bit_decoder import pcbd_pkg::*; #(
    parameter int NUM_CODES        = NUM_CODES_DEF,
    parameter int MAX_CODE_BITS    = MAX_CODE_BITS_DEF,
    parameter int MAX_SYMBOL_BYTES = MAX_SYMBOL_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    pcbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_is_bit (i_in.req_type == REQ_BIT),
        .i_cfg_valid (i_cfg_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    pcbd_datapath #(
        .NUM_CODES        (NUM_CODES),
        .MAX_CODE_BITS    (MAX_CODE_BITS),
        .MAX_SYMBOL_BYTES (MAX_SYMBOL_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (i_in),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

// ===== dv/decode_checker.sv =====
// Checker for the prefix code decoder: tracks requests, predicts results and compares them.
module decode_checker import pcbd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  t_in_item         i_in,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  t_out_item        i_out,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    logic [CODE_W-1:0]        code_tab     [NUM_CODES_DEF];
    logic [CLEN_W-1:0]        code_len_tab [NUM_CODES_DEF];
    logic [SYM_W-1:0]         sym_tab      [NUM_CODES_DEF];
    logic [SLEN_W-1:0]        sym_len_tab  [NUM_CODES_DEF];
    logic [NUM_CODES_DEF-1:0] live = '0;
    logic [CLEN_W-1:0]        code_pos = '0;
    logic [CFG_W-1:0]         entry_count = '0;
    t_out_item                expected_symbols [$];
    int                       fails = 0;

    task automatic clear_match();
        live = '0;
        code_pos = '0;
    endtask

    task automatic predict_request(input t_in_item req);
        int               count;
        int               i;
        int               sl;
        int               len;
        logic             hit;
        logic             done;
        logic             m;
        logic [SYM_W-1:0] mask;
        t_out_item        res;
        if (req.req_type == REQ_WRITE) begin
            code_tab[req.entry_index]     = req.entry_code;
            code_len_tab[req.entry_index] = req.entry_code_length;
            sym_tab[req.entry_index]      = req.entry_symbol;
            sym_len_tab[req.entry_index]  = req.entry_symbol_length;
            clear_match();
        end else begin
            count = (int'(entry_count) > NUM_CODES_DEF) ? NUM_CODES_DEF : int'(entry_count);
            hit = 1'b0;
            done = 1'b0;
            for (i = 0; i < count && !done; i++) begin
                len = int'(code_len_tab[i]);
                m = 1'b0;
                if (len >= 1 && len <= MAX_CODE_BITS_DEF && int'(code_pos) < len) begin
                    m = (code_pos == 0 || live[i]) && code_tab[i][code_pos] == req.code_bit;
                end
                live[i] = m;
                if (m) begin
                    hit = 1'b1;
                    if (len == int'(code_pos) + 1) begin
                        sl = int'(sym_len_tab[i]);
                        if (sl > MAX_SYMBOL_BYTES_DEF) sl = MAX_SYMBOL_BYTES_DEF;
                        mask = (sl >= 8) ? {SYM_W{1'b1}} :
                               ((SYM_W'(1) << (8 * sl)) - SYM_W'(1));
                        res.status        = STATUS_OK;
                        res.matched_index = IDX_FIELD_W'(i);
                        res.symbol_word   = sym_tab[i] & mask;
                        res.symbol_length = SLEN_W'(sl);
                        expected_symbols.push_back(res);
                        clear_match();
                        done = 1'b1;
                    end
                end
            end
            if (!done) begin
                if (!hit) begin
                    res.status        = STATUS_BAD;
                    res.matched_index = '0;
                    res.symbol_word   = '0;
                    res.symbol_length = '0;
                    expected_symbols.push_back(res);
                    clear_match();
                end else begin
                    code_pos = code_pos + 1'b1;
                end
            end
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item exp;
        if (expected_symbols.size() == 0) begin
            fails++;
            if (fails <= 10) begin
                $display("unexpected result: status %0d index %0d symbol %h length %0d",
                         got.status, got.matched_index, got.symbol_word, got.symbol_length);
            end
        end else begin
            exp = expected_symbols.pop_front();
            if (got.status !== exp.status || got.matched_index !== exp.matched_index ||
                got.symbol_word !== exp.symbol_word ||
                got.symbol_length !== exp.symbol_length) begin
                fails++;
                if (fails <= 10) begin
                    $display("mismatch: exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                             exp.status, exp.matched_index, exp.symbol_word,
                             exp.symbol_length, got.status, got.matched_index,
                             got.symbol_word, got.symbol_length);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_count = '0;
            clear_match();
            expected_symbols.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                entry_count = i_cfg_data;
                clear_match();
            end
            if (i_in_valid && !i_in_stall) predict_request(i_in);
            if (i_out_valid && !i_out_stall) check_result(i_out);
        end
        o_pending = expected_symbols.size();
        o_fail_count = fails;
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the prefix code decoder: table loads, code streams, stalls and verdict.
module tb;
    import pcbd_pkg::*;

    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int ITEM_TARGET    = 900;
    localparam int QUIET_FROM     = 800;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_in_item         in_req = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_out_item        out_item;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data = '0;
    int               fail_count;
    int               pending;

    logic [CODE_W-1:0] slot_code [NUM_CODES_DEF];
    int                slot_len  [NUM_CODES_DEF];
    int                sent = 0;
    int                idle_cycles = 0;
    int                hold_ask = 0;
    logic              quiet = 1'b0;

    always #5 clk = ~clk;

    prefix_code_bit_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    decode_checker result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_req(input t_in_item r);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= r;
        do @(posedge clk); while (in_stall);
        sent++;
        if (sent >= QUIET_FROM) quiet <= 1'b1;
    endtask

    function automatic t_in_item noise_req();
        logic [127:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        return noise[$bits(t_in_item)-1:0];
    endfunction

    task automatic write_slot(input int idx, input logic [CODE_W-1:0] code, input int len,
                              input logic [SYM_W-1:0] sym, input int slen);
        t_in_item r;
        r = noise_req();
        r.req_type            = REQ_WRITE;
        r.entry_index         = IDX_FIELD_W'(idx);
        r.entry_code          = code;
        r.entry_code_length   = CLEN_W'(len);
        r.entry_symbol        = sym;
        r.entry_symbol_length = SLEN_W'(slen);
        send_req(r);
        slot_code[idx] = code;
        slot_len[idx]  = len & 31;
    endtask

    task automatic send_bit(input logic b);
        t_in_item r;
        r = noise_req();
        r.req_type = REQ_BIT;
        r.code_bit = b;
        send_req(r);
    endtask

    function automatic int random_sym_len();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
    endfunction

    task automatic write_random_slot(input int idx);
        int len;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 29);
        write_slot(idx, CODE_W'($urandom), len, {$urandom, $urandom}, random_sym_len());
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_count(input int v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= CFG_W'(v);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_prefix_code(input int n);
        logic [CODE_W-1:0] codes [NUM_CODES_DEF];
        int                lens  [NUM_CODES_DEF];
        int                leaves;
        int                pick;
        int                s;
        codes[0] = '0;
        lens[0]  = 1;
        codes[1] = CODE_W'(1);
        lens[1]  = 1;
        leaves   = 2;
        while (leaves < n) begin
            pick = ($urandom_range(0, 1) == 0) ? leaves - 1 : $urandom_range(0, leaves - 1);
            while (lens[pick] >= MAX_CODE_BITS_DEF) pick = $urandom_range(0, leaves - 1);
            codes[leaves] = codes[pick] | (CODE_W'(1) << lens[pick]);
            lens[leaves]  = lens[pick] + 1;
            lens[pick]++;
            leaves++;
        end
        for (s = 0; s < n; s++) begin
            write_slot(s, codes[s], lens[s], {$urandom, $urandom}, random_sym_len());
        end
    endtask

    task automatic send_codeword(input int s);
        int b;
        if (slot_len[s] >= 1 && slot_len[s] <= MAX_CODE_BITS_DEF) begin
            for (b = 0; b < slot_len[s]; b++) send_bit(slot_code[s][b]);
        end else begin
            repeat ($urandom_range(1, 4)) send_bit(1'($urandom_range(0, 1)));
        end
    endtask

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int phase;
        int n;
        int count;
        int lim;
        int stream_end;
        int pick;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // empty table: every bit is an invalid code
        set_count(0);
        send_bit(1'b0);
        send_bit(1'b1);

        write_slot(0, '0, 1, {$urandom, $urandom}, 0);
        write_slot(1, CODE_W'(1), 2, {SYM_W{1'b1}}, 8);
        write_slot(2, {CODE_W{1'b1}}, MAX_CODE_BITS_DEF, {$urandom, $urandom}, 15);
        write_slot(3, CODE_W'($urandom), 0, {$urandom, $urandom}, 3);
        write_slot(4, CODE_W'($urandom), 30, {$urandom, $urandom}, 4);
        write_slot(5, '0, 31, {$urandom, $urandom}, 5);
        write_slot(6, CODE_W'(1), 2, {$urandom, $urandom}, 2);
        set_count(7);
        send_bit(1'b0);
        send_bit(1'b1);
        send_bit(1'b0);
        repeat (MAX_CODE_BITS_DEF) send_bit(1'b1);
        send_bit(1'b1);
        send_bit(1'b1);
        send_bit(1'b0);
        // table write mid-code: restart matching
        send_bit(1'b1);
        write_slot(6, CODE_W'(1), 2, {$urandom, $urandom}, 9);
        send_bit(1'b0);

        phase = 0;
        while (sent < ITEM_TARGET) begin
            n = ($urandom_range(0, 7) == 0) ? NUM_CODES_DEF : $urandom_range(2, 16);
            case ($urandom_range(0, 9))
                0: begin
                    count = 0;
                end
                1: begin
                    count = $urandom_range(NUM_CODES_DEF + 1, 127);
                end
                2: begin
                    count = $urandom_range(1, NUM_CODES_DEF);
                end
                default: begin
                    count = n;
                end
            endcase
            if (phase == 0) begin
                n = NUM_CODES_DEF;
                count = 127;
            end else if (phase == 1) begin
                count = NUM_CODES_DEF;
            end else if (phase == 2) begin
                count = 1;
            end
            set_count(count);
            if (phase == 0 || $urandom_range(0, 3) != 0) load_prefix_code(n);
            if ($urandom_range(0, 2) == 0) begin
                pick = $urandom_range(0, NUM_CODES_DEF - 2);
                write_slot($urandom_range(pick + 1, NUM_CODES_DEF - 1), slot_code[pick],
                           slot_len[pick], {$urandom, $urandom}, random_sym_len());
            end
            if (phase == 3) hold_ask <= hold_ask + 1;
            lim = (count > NUM_CODES_DEF) ? NUM_CODES_DEF : count;
            stream_end = sent + $urandom_range(40, 120);
            while (sent < stream_end) begin
                pick = $urandom_range(0, 19);
                if (pick == 0 || lim == 0) begin
                    send_bit(1'($urandom_range(0, 1)));
                end else if (pick == 1) begin
                    write_random_slot($urandom_range(0, NUM_CODES_DEF - 1));
                end else if (pick == 2 && !quiet) begin
                    in_valid <= 1'b0;
                    do @(negedge clk); while (pending != 0);
                    @(posedge clk);
                end else begin
                    send_codeword($urandom_range(0, lim - 1));
                end
            end
            phase++;
        end

        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== prefix_code_bit_decoder.f =====
+incdir+rtl
rtl/pcbd_pkg.sv
rtl/pcbd_datapath.sv
rtl/pcbd_ctrl.sv
rtl/prefix_code_bit_decoder.sv
dv/decode_checker.sv
dv/tb.sv
